// File: rtl/core/svp_pkg.sv
// Shared types, codes and constants for the sensor value converter.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package svp_pkg;

  localparam int DEFAULT_FRAC_BITS = 8;
  localparam int NUM_W = 50;
  localparam int DVS_W = 16;
  localparam int DIV_STAGES = NUM_W / 2;
  localparam int VAL_W = 32;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y2    = 3'd5;

  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_ZERO   = 3'd1;
  localparam logic [2:0] MODE_LINEAR = 3'd2;
  localparam logic [2:0] MODE_TEMP   = 3'd3;
  localparam logic [2:0] MODE_TEMPHI = 3'd4;

  localparam logic [4:0] DEPTH_MIN = 5'd6;
  localparam logic [4:0] DEPTH_MAX = 5'd16;

  typedef enum logic [3:0] {
    ST_OK, ST_INIT, ST_INVALID, ST_FUNCTION, ST_GENERIC,
    ST_RESERVED, ST_OEM, ST_PRODUCTION, ST_UNEXPECTED, ST_NOTCONV
  } status_t;

  typedef enum logic [1:0] {SEL_CONST, SEL_LIN, SEL_TEMP} sel_t;

  typedef enum logic [1:0] {TK_DEF12, TK_DEF10, TK_DEF8, TK_HI12} temp_kind_t;

  typedef struct packed {
    sel_t                     sel;
    status_t                  status;
    logic                     neg;
    logic signed [VAL_W-1:0]  const_val;
  } side_t;

  function automatic status_t top_code_status(input logic [2:0] k);
    status_t s;
    unique case (k)
      3'd0: s = ST_INVALID;
      3'd1: s = ST_FUNCTION;
      3'd2: s = ST_GENERIC;
      3'd5: s = ST_OEM;
      3'd6: s = ST_PRODUCTION;
      default: s = ST_RESERVED;
    endcase
    return s;
  endfunction

  // slope * (offset * 100 - 27315) for each temperature scale.
  function automatic logic signed [24:0] temp_offset(input temp_kind_t k);
    logic signed [24:0] v;
    unique case (k)
      TK_DEF12: v = -25'sd58520;
      TK_DEF10: v = -25'sd21260;
      TK_DEF8:  v = -25'sd5315;
      TK_HI12:  v = -25'sd21945;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // 100 * slope for each temperature scale.
  function automatic logic signed [16:0] temp_divisor(input temp_kind_t k);
    logic signed [16:0] v;
    unique case (k)
      TK_DEF12: v = 17'sd800;
      TK_DEF10: v = 17'sd400;
      TK_DEF8:  v = 17'sd100;
      TK_HI12:  v = 17'sd300;
      default:  v = 17'sd1;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/svp_front.sv
// Front stages: error decode, operand forming, multiply and magnitude set-up.
// Depends on svp_pkg; feeds the divider with an unsigned dividend and divisor.
`timescale 1ns / 1ps

module svp_front #(
  parameter int VALUE_FRAC_BITS = svp_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [15:0]                         raw_sample,
  input  logic [2:0]                          mode,
  input  logic [4:0]                          depth,
  input  logic signed [svp_pkg::VAL_W-1:0]    x1,
  input  logic signed [svp_pkg::VAL_W-1:0]    x2,
  input  logic [15:0]                         y1,
  input  logic [15:0]                         y2,
  output logic                                o_valid,
  output logic [svp_pkg::NUM_W-1:0]           o_dvd,
  output logic [svp_pkg::DVS_W-1:0]           o_dvs,
  output svp_pkg::side_t                      o_side
);

  localparam int NW = svp_pkg::NUM_W;
  localparam int VW = svp_pkg::VAL_W;
  localparam int DVS_W_L = svp_pkg::DVS_W;

  logic [4:0]             d_cl;
  logic [16:0]            maxv;
  logic [16:0]            highv;
  logic [16:0]            raw17;
  svp_pkg::status_t       chk;
  svp_pkg::side_t         side1_next;
  svp_pkg::temp_kind_t    tk_next;

  logic                   s1_valid;
  svp_pkg::side_t         s1_side;
  svp_pkg::temp_kind_t    s1_tk;
  logic [15:0]            s1_raw;
  logic signed [32:0]     s1_dx;
  logic signed [16:0]     s1_dr;
  logic signed [16:0]     s1_dy;

  logic signed [24:0]     tbase;
  logic signed [NW-1:0]   tnum;
  logic                   s2_valid;
  svp_pkg::side_t         s2_side;
  logic signed [NW-1:0]   s2_num;
  logic signed [16:0]     s2_den;

  logic [NW-1:0]          mag_num;
  logic [DVS_W_L-1:0]     mag_den;
  svp_pkg::side_t         side3_next;

  always_comb begin
    priority if (depth < svp_pkg::DEPTH_MIN) begin
      d_cl = svp_pkg::DEPTH_MIN;
    end else if (depth > svp_pkg::DEPTH_MAX) begin
      d_cl = svp_pkg::DEPTH_MAX;
    end else begin
      d_cl = depth;
    end
    maxv  = 17'((17'd1 << d_cl) - 17'd1);
    highv = 17'(maxv - 17'd7);
    raw17 = {1'b0, raw_sample};
    priority if (raw_sample == 16'd0) begin
      chk = svp_pkg::ST_INIT;
    end else if (raw17 > maxv) begin
      chk = svp_pkg::ST_PRODUCTION;
    end else if (raw17 >= highv) begin
      chk = svp_pkg::top_code_status(3'(raw17 - highv));
    end else begin
      chk = svp_pkg::ST_OK;
    end
  end

  always_comb begin
    side1_next.sel       = svp_pkg::SEL_CONST;
    side1_next.status    = svp_pkg::ST_NOTCONV;
    side1_next.neg       = 1'b0;
    side1_next.const_val = '0;
    tk_next              = svp_pkg::TK_DEF12;
    priority if (mode == svp_pkg::MODE_ZERO) begin
      side1_next.status = (raw_sample != 16'd0) ? svp_pkg::ST_UNEXPECTED : svp_pkg::ST_OK;
    end else if (mode == svp_pkg::MODE_LINEAR) begin
      side1_next.status = chk;
      if (chk != svp_pkg::ST_OK) begin
        side1_next.const_val = VW'(-32'sd999 <<< VALUE_FRAC_BITS);
      end else begin
        side1_next.sel = svp_pkg::SEL_LIN;
      end
    end else if (mode == svp_pkg::MODE_TEMP || mode == svp_pkg::MODE_TEMPHI) begin
      side1_next.status = chk;
      priority if (chk != svp_pkg::ST_OK) begin
        side1_next.const_val = '0;
      end else if (d_cl != 5'd8 && d_cl != 5'd10 && d_cl != 5'd12) begin
        side1_next.const_val = VW'(-32'sd1 <<< VALUE_FRAC_BITS);
      end else if (mode == svp_pkg::MODE_TEMPHI) begin
        if (d_cl != 5'd12) begin
          side1_next.const_val = VW'(-32'sd3 <<< VALUE_FRAC_BITS);
        end else begin
          side1_next.sel = svp_pkg::SEL_TEMP;
          tk_next        = svp_pkg::TK_HI12;
        end
      end else begin
        side1_next.sel = svp_pkg::SEL_TEMP;
        priority if (d_cl == 5'd12) begin
          tk_next = svp_pkg::TK_DEF12;
        end else if (d_cl == 5'd10) begin
          tk_next = svp_pkg::TK_DEF10;
        end else begin
          tk_next = svp_pkg::TK_DEF8;
        end
      end
    end else begin
      side1_next.status = svp_pkg::ST_NOTCONV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      o_valid  <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= side1_next;
      s1_tk   <= tk_next;
      s1_raw  <= raw_sample;
      s1_dx   <= 33'({x2[VW-1], x2}) - 33'({x1[VW-1], x1});
      s1_dr   <= signed'({1'b0, raw_sample}) - signed'({1'b0, y1});
      s1_dy   <= signed'({1'b0, y2}) - signed'({1'b0, y1});
    end
  end

  always_comb begin
    tbase = signed'({9'd0, s1_raw}) * 25'sd100 + svp_pkg::temp_offset(s1_tk);
    tnum  = NW'(tbase) <<< VALUE_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side <= s1_side;
      if (s1_side.sel == svp_pkg::SEL_LIN) begin
        s2_num <= NW'(s1_dx * s1_dr);
        s2_den <= s1_dy;
      end else begin
        s2_num <= tnum;
        s2_den <= svp_pkg::temp_divisor(s1_tk);
      end
    end
  end

  always_comb begin
    side3_next = s2_side;
    mag_num = s2_num[NW-1] ? NW'(-s2_num) : NW'(s2_num);
    mag_den = s2_den[16] ? DVS_W_L'(-s2_den) : DVS_W_L'(s2_den);
    side3_next.neg = s2_num[NW-1] ^ s2_den[16];
    if (s2_side.sel == svp_pkg::SEL_LIN && s2_den == 17'sd0) begin
      side3_next.sel = svp_pkg::SEL_CONST;
      priority if (s2_num > 0) begin
        side3_next.const_val = {1'b0, {(VW-1){1'b1}}};
      end else if (s2_num < 0) begin
        side3_next.const_val = {1'b1, {(VW-1){1'b0}}};
      end else begin
        side3_next.const_val = x1;
      end
      mag_den = DVS_W_L'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_side <= side3_next;
      o_dvs  <= mag_den;
      o_dvd  <= NW'(mag_num + NW'(mag_den >> 1));
    end
  end

endmodule

// File: rtl/core/svp_divider.sv
// Pipelined restoring divider, two quotient bits per register stage.
// Depends on svp_pkg; carries the side information of each item alongside.
`timescale 1ns / 1ps

module svp_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          i_valid,
  input  logic [svp_pkg::NUM_W-1:0]     i_dvd,
  input  logic [svp_pkg::DVS_W-1:0]     i_dvs,
  input  svp_pkg::side_t                i_side,
  output logic                          o_valid,
  output logic [svp_pkg::NUM_W-1:0]     o_quo,
  output svp_pkg::side_t                o_side
);

  localparam int NW = svp_pkg::NUM_W;
  localparam int DW = svp_pkg::DVS_W;
  localparam int NS = svp_pkg::DIV_STAGES;

  logic [NS-1:0]  vld;
  logic [DW-1:0]  rem_q [0:NS-1];
  logic [NW-1:0]  dvd_q [0:NS-1];
  logic [NW-1:0]  quo_q [0:NS-1];
  logic [DW-1:0]  dvs_q [0:NS-1];
  svp_pkg::side_t side_q [0:NS-1];

  logic [DW-1:0]  rem_s [0:NS-1];
  logic [NW-1:0]  dvd_s [0:NS-1];
  logic [NW-1:0]  quo_s [0:NS-1];
  logic [DW-1:0]  dvs_s [0:NS-1];
  svp_pkg::side_t side_s [0:NS-1];

  logic [DW-1:0]  rem_n [0:NS-1];
  logic [1:0]     qb_n  [0:NS-1];

  always_comb begin
    rem_s[0]  = '0;
    dvd_s[0]  = i_dvd;
    quo_s[0]  = '0;
    dvs_s[0]  = i_dvs;
    side_s[0] = i_side;
    for (int s = 1; s < NS; s++) begin
      rem_s[s]  = rem_q[s-1];
      dvd_s[s]  = dvd_q[s-1];
      quo_s[s]  = quo_q[s-1];
      dvs_s[s]  = dvs_q[s-1];
      side_s[s] = side_q[s-1];
    end
  end

  always_comb begin
    logic [DW:0]   t1;
    logic [DW:0]   t2;
    logic [DW-1:0] r1;
    for (int s = 0; s < NS; s++) begin
      t1 = {rem_s[s], dvd_s[s][NW-1]};
      qb_n[s][1] = (t1 >= {1'b0, dvs_s[s]});
      r1 = qb_n[s][1] ? DW'(t1 - {1'b0, dvs_s[s]}) : DW'(t1);
      t2 = {r1, dvd_s[s][NW-2]};
      qb_n[s][0] = (t2 >= {1'b0, dvs_s[s]});
      rem_n[s] = qb_n[s][0] ? DW'(t2 - {1'b0, dvs_s[s]}) : DW'(t2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s]  <= rem_n[s];
        dvd_q[s]  <= dvd_s[s] << 2;
        quo_q[s]  <= {quo_s[s][NW-3:0], qb_n[s]};
        dvs_q[s]  <= dvs_s[s];
        side_q[s] <= side_s[s];
      end
    end
  end

  assign o_valid = vld[NS-1];
  assign o_quo   = quo_q[NS-1];
  assign o_side  = side_q[NS-1];

endmodule

// File: rtl/core/svp_back.sv
// Output stage: applies the sign, adds x1 if linear, saturates, registers.
// Depends on svp_pkg; holds the result register seen at the output channel.
`timescale 1ns / 1ps

module svp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              i_valid,
  input  logic [svp_pkg::NUM_W-1:0]         i_quo,
  input  svp_pkg::side_t                    i_side,
  input  logic signed [svp_pkg::VAL_W-1:0]  x1,
  output logic                              out_valid,
  output logic signed [svp_pkg::VAL_W-1:0]  phys_value,
  output logic [3:0]                        status_code
);

  localparam int SW = svp_pkg::NUM_W + 2;
  localparam int VW = svp_pkg::VAL_W;

  logic signed [SW-1:0] sq;
  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] val_next;

  always_comb begin
    sq  = i_side.neg ? -signed'({2'b00, i_quo}) : signed'({2'b00, i_quo});
    sum = (i_side.sel == svp_pkg::SEL_LIN) ? SW'(sq + SW'(x1)) : sq;
    priority if (i_side.sel == svp_pkg::SEL_CONST) begin
      val_next = i_side.const_val;
    end else if (sum > signed'(SW'({1'b0, {(VW-1){1'b1}}}))) begin
      val_next = {1'b0, {(VW-1){1'b1}}};
    end else if (sum < -signed'(SW'({1'b0, 1'b1, {(VW-1){1'b0}}}))) begin
      val_next = {1'b1, {(VW-1){1'b0}}};
    end else begin
      val_next = VW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phys_value  <= val_next;
      status_code <= i_side.status;
    end
  end

endmodule

// File: rtl/core/sent_value_to_physical_unit.sv
// Top level of the sensor value converter: configuration registers and pipeline.
// Depends on svp_pkg, svp_front, svp_divider and svp_back.
//
// Usage: raw_sample is transferred when in_valid is high and in_stall is low;
// a result (phys_value, status_code) is transferred when out_valid is high
// and out_stall is low. Every sample gives exactly one result, in order.
// There are three front stages (decode, multiply, magnitude), 25 divider stages
// of two quotient bits each, and the output register. One sample per cycle is
// taken unless stalled; the pipelined divider sets the depth. When the receiver
// stalls with a result waiting, the whole pipeline holds and in_stall is
// raised, so nothing is lost or repeated; empty stages are not collapsed. The
// user must write configuration through cfg_write, cfg_index and cfg_data only
// while no sample is in flight; the block does not enforce this. A synchronous
// reset empties the pipeline; it resets only valid and configuration registers.
`timescale 1ns / 1ps

module sent_value_to_physical_unit #(
  parameter int VALUE_FRAC_BITS = svp_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [svp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [svp_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       raw_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [svp_pkg::VAL_W-1:0]  phys_value,
  output logic [3:0]                        status_code
);

  logic [2:0]                      mode;
  logic [4:0]                      depth;
  logic signed [svp_pkg::VAL_W-1:0] x1;
  logic signed [svp_pkg::VAL_W-1:0] x2;
  logic [15:0]                     y1;
  logic [15:0]                     y2;
  logic                            adv;

  logic                            f_valid;
  logic [svp_pkg::NUM_W-1:0]       f_dvd;
  logic [svp_pkg::DVS_W-1:0]       f_dvs;
  svp_pkg::side_t                  f_side;
  logic                            d_valid;
  logic [svp_pkg::NUM_W-1:0]       d_quo;
  svp_pkg::side_t                  d_side;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= svp_pkg::MODE_NONE;
      depth <= 5'd12;
      x1    <= '0;
      x2    <= '0;
      y1    <= '0;
      y2    <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        svp_pkg::CFG_MODE:  mode  <= cfg_data[2:0];
        svp_pkg::CFG_DEPTH: depth <= cfg_data[4:0];
        svp_pkg::CFG_X1:    x1    <= signed'(cfg_data);
        svp_pkg::CFG_X2:    x2    <= signed'(cfg_data);
        svp_pkg::CFG_Y1:    y1    <= cfg_data[15:0];
        svp_pkg::CFG_Y2:    y2    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  svp_front #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid), .raw_sample(raw_sample),
    .mode(mode), .depth(depth), .x1(x1), .x2(x2), .y1(y1), .y2(y2),
    .o_valid(f_valid), .o_dvd(f_dvd), .o_dvs(f_dvs), .o_side(f_side)
  );

  svp_divider u_div (
    .clk(clk), .rst(rst), .adv(adv), .i_valid(f_valid), .i_dvd(f_dvd),
    .i_dvs(f_dvs), .i_side(f_side), .o_valid(d_valid), .o_quo(d_quo),
    .o_side(d_side)
  );

  svp_back u_back (
    .clk(clk), .rst(rst), .adv(adv), .i_valid(d_valid), .i_quo(d_quo),
    .i_side(d_side), .x1(x1), .out_valid(out_valid), .phys_value(phys_value),
    .status_code(status_code)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  a_notconv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_code == svp_pkg::ST_NOTCONV |-> phys_value == '0)
    else $error("unconverted result carries a value");

  a_unexp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_code == svp_pkg::ST_UNEXPECTED |-> phys_value == '0)
    else $error("unexpected zero channel result carries a value");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status_code <= svp_pkg::ST_NOTCONV)
    else $error("status code out of range");

endmodule
